[design/ocp_pkg.sv]
`timescale 1ns / 1ps

package ocp_pkg;

	// Iteration count of the rotation unit. The arctangent table holds 24 entries.
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam int CNT_W        = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;
	localparam int ATAN_IDX_W   = 5;

	// Vector components are Q2.30, angles are degrees * 65536.
	localparam int VEC_W = 32;
	localparam int ANG_W = 25;
	localparam int PRD_W = 64;

	localparam logic signed [VEC_W-1:0] GAIN_INV_Q30 = 32'sd652032874;

	localparam logic [16:0] YAW_FULL    = 17'd92160;
	localparam logic [16:0] YAW_HALF    = 17'd46080;
	localparam logic [16:0] QUARTER     = 17'd23040;
	localparam logic [16:0] PITCH_LIMIT = 17'd22784;
	localparam logic [16:0] RADIUS_MIN  = 17'd256;
	localparam logic [16:0] RADIUS_MAX  = 17'd23040;

	localparam logic [16:0] SPEED_RESET  = 17'd256;
	localparam logic [16:0] YAW_RESET    = 17'd3840;
	localparam logic [16:0] PITCH_RESET  = 17'd1920;
	localparam logic [16:0] RADIUS_RESET = 17'd3840;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_UPDATE,
		ST_PITCH,
		ST_YAW,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_MUL_D,
		ST_MUL_E,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    done;
		logic signed [VEC_W-1:0] cos_v;
		logic signed [VEC_W-1:0] sin_v;
	} cordic_res_t;

	// atan(2^-i) in degrees * 65536, rounded to nearest.
	function automatic logic [22:0] atan_deg16(input logic [ATAN_IDX_W-1:0] idx);
		logic [22:0] v;
		case (idx)
			5'd0:    v = 23'd2949120;
			5'd1:    v = 23'd1740967;
			5'd2:    v = 23'd919879;
			5'd3:    v = 23'd466945;
			5'd4:    v = 23'd234379;
			5'd5:    v = 23'd117304;
			5'd6:    v = 23'd58666;
			5'd7:    v = 23'd29335;
			5'd8:    v = 23'd14668;
			5'd9:    v = 23'd7334;
			5'd10:   v = 23'd3667;
			5'd11:   v = 23'd1833;
			5'd12:   v = 23'd917;
			5'd13:   v = 23'd458;
			5'd14:   v = 23'd229;
			5'd15:   v = 23'd115;
			5'd16:   v = 23'd57;
			5'd17:   v = 23'd29;
			5'd18:   v = 23'd14;
			5'd19:   v = 23'd7;
			5'd20:   v = 23'd4;
			5'd21:   v = 23'd2;
			5'd22:   v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

	// Round a product to nearest by 2^30, ties toward plus infinity.
	function automatic logic signed [33:0] rnd30(input logic signed [PRD_W-1:0] v);
		logic signed [PRD_W-1:0] t;
		t = v + 64'sd536870912;
		return t[63:30];
	endfunction

	function automatic logic signed [15:0] clamp_eye(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > $signed({17'd0, QUARTER}))
			r = 16'sd23040;
		else if (v < -$signed({17'd0, QUARTER}))
			r = -16'sd23040;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

[design/ocp_mul.sv]
`timescale 1ns / 1ps

module ocp_mul
	import ocp_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VEC_W-1:0] a,
	input  logic signed [VEC_W-1:0] b,
	output logic signed [PRD_W-1:0] p
);

	logic signed [PRD_W-1:0] p_q;

	// The product holds while en is low, so it can be read in later states.
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= PRD_W'(a) * PRD_W'(b);
		end
	end

	assign p = p_q;

endmodule

[design/ocp_cordic.sv]
`timescale 1ns / 1ps

module ocp_cordic
	import ocp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ANG_W-1:0] angle,
	output cordic_res_t             res
);

	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q, done_q;

	logic signed [VEC_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] at;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = $signed(ANG_W'(atan_deg16(ATAN_IDX_W'(cnt_q))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(CORDIC_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// One micro-rotation per cycle; the sign of the residual angle picks the direction.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= GAIN_INV_Q30;
			y_q <= '0;
			z_q <= angle;
		end else if (busy_q) begin
			if (!z_q[ANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = x_q;
	assign res.sin_v = y_q;

endmodule

[design/orbit_camera_position_update.sv]
`timescale 1ns / 1ps
// A new item is accepted only once the previous result is in the output register.
// Each item makes two passes through the shared CORDIC rotation unit (pitch, then yaw)
// and six passes through the shared multiplier.
// A finished result waits in the output register while the next item is accepted.
// Reset: yaw 15.0, pitch 7.5, radius 15.0, move_speed 1.0; no result pending.
module orbit_camera_position_update
	import ocp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] turn_left, [1] turn_right, [2] tilt_up, [3] tilt_down, [4] zoom_closer,
	// [5] zoom_farther, [21:6] elapsed_time, [23:22] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] eye_x, [31:16] eye_y, [47:32] eye_z, [64:48] yaw_now,
	// [80:65] pitch_now, [95:81] radius_now
	output logic [95:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	state_t state_q, state_next;

	logic [15:0]        speed_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic [14:0]        radius_q;

	logic [5:0]         keys_q;
	logic [15:0]        et_q;
	logic signed [VEC_W-1:0] cp_q, sp_q, cy_q, sy_q;
	logic               flip_q;
	logic signed [15:0] ex_q, ey_q;
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;

	logic                    cor_start;
	logic signed [ANG_W-1:0] cor_angle;
	cordic_res_t             cor_res;

	logic                    mul_en;
	logic signed [VEC_W-1:0] mul_a, mul_b;
	logic signed [PRD_W-1:0] prod;

	ocp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.res    (cor_res)
	);

	ocp_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// delta = (elapsed_time * move_speed + 0.5) in Q.8.
	logic [32:0] dsum;
	logic [16:0] delta;
	assign dsum  = {1'b0, prod[31:0]} + 33'd32768;
	assign delta = dsum[32:16];

	logic [17:0] yaw1, yaw2, yaw_add, yaw_sub;
	logic signed [18:0] p_raw, r_raw, p_next, r_next;

	always_comb begin
		yaw_add = {1'b0, yaw_q} + {1'b0, delta};
		yaw1    = {1'b0, yaw_q};
		if (keys_q[0])
			yaw1 = (yaw_add >= {1'b0, YAW_FULL}) ? yaw_add - {1'b0, YAW_FULL} : yaw_add;
		yaw_sub = yaw1 + {1'b0, YAW_FULL} - {1'b0, delta};
		yaw2    = yaw1;
		if (keys_q[1])
			yaw2 = (yaw_sub >= {1'b0, YAW_FULL}) ? yaw_sub - {1'b0, YAW_FULL} : yaw_sub;

		p_raw = 19'(pitch_q);
		if (keys_q[2]) p_raw = p_raw + $signed({2'b00, delta});
		if (keys_q[3]) p_raw = p_raw - $signed({2'b00, delta});
		r_raw = $signed({4'd0, radius_q});
		if (keys_q[4]) r_raw = r_raw - $signed({2'b00, delta});
		if (keys_q[5]) r_raw = r_raw + $signed({2'b00, delta});

		if (p_raw > $signed({2'b00, PITCH_LIMIT}))
			p_next = $signed({2'b00, PITCH_LIMIT});
		else if (p_raw < -$signed({2'b00, PITCH_LIMIT}))
			p_next = -$signed({2'b00, PITCH_LIMIT});
		else
			p_next = p_raw;
		if (r_raw < $signed({2'b00, RADIUS_MIN}))
			r_next = $signed({2'b00, RADIUS_MIN});
		else if (r_raw > $signed({2'b00, RADIUS_MAX}))
			r_next = $signed({2'b00, RADIUS_MAX});
		else
			r_next = r_raw;
	end

	// Yaw is folded into -90..+90 degrees; a half-turn fold negates cos and sin.
	logic signed [18:0] ya0, ya1;
	logic               flip_next;

	always_comb begin
		ya0 = $signed({2'b00, yaw_q});
		if (ya0 > $signed({2'b00, YAW_HALF}))
			ya0 = ya0 - $signed({2'b00, YAW_FULL});
		ya1       = ya0;
		flip_next = 1'b0;
		if (ya0 > $signed({2'b00, QUARTER})) begin
			ya1       = ya0 - $signed({2'b00, YAW_HALF});
			flip_next = 1'b1;
		end else if (ya0 < -$signed({2'b00, QUARTER})) begin
			ya1       = ya0 + $signed({2'b00, YAW_HALF});
			flip_next = 1'b1;
		end
	end

	logic signed [VEC_W-1:0] f_val;
	logic signed [15:0]      eye_val;
	logic                    out_free;

	assign f_val    = VEC_W'(rnd30(prod));
	assign eye_val  = clamp_eye(rnd30(prod));
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_next = ST_DELTA;
			ST_DELTA:  state_next = ST_UPDATE;
			ST_UPDATE: state_next = ST_PITCH;
			ST_PITCH:  if (cor_res.done) state_next = ST_YAW;
			ST_YAW:    if (cor_res.done) state_next = ST_MUL_A;
			ST_MUL_A:  state_next = ST_MUL_B;
			ST_MUL_B:  state_next = ST_MUL_C;
			ST_MUL_C:  state_next = ST_MUL_D;
			ST_MUL_D:  state_next = ST_MUL_E;
			ST_MUL_E:  state_next = ST_DONE;
			ST_DONE:   if (out_free) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cor_start = 1'b0;
		cor_angle = '0;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_DELTA: begin
				mul_en = 1'b1;
				mul_a  = $signed({16'd0, et_q});
				mul_b  = $signed({16'd0, speed_q});
			end
			ST_UPDATE: begin
				cor_start = 1'b1;
				cor_angle = ANG_W'({p_next, 8'd0});
			end
			ST_PITCH: begin
				cor_start = cor_res.done;
				cor_angle = ANG_W'({ya1, 8'd0});
			end
			ST_MUL_A: begin
				mul_en = 1'b1;
				mul_a  = cp_q;
				mul_b  = cy_q;
			end
			ST_MUL_B: begin
				mul_en = 1'b1;
				mul_a  = $signed({17'd0, radius_q});
				mul_b  = f_val;
			end
			ST_MUL_C: begin
				mul_en = 1'b1;
				mul_a  = $signed({17'd0, radius_q});
				mul_b  = sp_q;
			end
			ST_MUL_D: begin
				mul_en = 1'b1;
				mul_a  = cp_q;
				mul_b  = sy_q;
			end
			ST_MUL_E: begin
				mul_en = 1'b1;
				mul_a  = $signed({17'd0, radius_q});
				mul_b  = f_val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			speed_q    <= SPEED_RESET[15:0];
			yaw_q      <= YAW_RESET;
			pitch_q    <= $signed(PITCH_RESET[15:0]);
			radius_q   <= RADIUS_RESET[14:0];
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_valid && cfg_ready)
				speed_q <= cfg_data;
			if (state_q == ST_UPDATE) begin
				yaw_q    <= yaw2[16:0];
				pitch_q  <= p_next[15:0];
				radius_q <= r_next[14:0];
			end
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			keys_q <= s_tdata[5:0];
			et_q   <= s_tdata[21:6];
		end
		if (state_q == ST_PITCH && cor_res.done) begin
			cp_q   <= cor_res.cos_v;
			sp_q   <= cor_res.sin_v;
			flip_q <= flip_next;
		end
		if (state_q == ST_YAW && cor_res.done) begin
			cy_q <= flip_q ? -cor_res.cos_v : cor_res.cos_v;
			sy_q <= flip_q ? -cor_res.sin_v : cor_res.sin_v;
		end
		if (state_q == ST_MUL_C)
			ex_q <= eye_val;
		if (state_q == ST_MUL_D)
			ey_q <= eye_val;
		if (state_q == ST_DONE && out_free)
			m_tdata_q <= {radius_q, pitch_q, yaw_q, eye_val, ey_q, ex_q};
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule

[bench/orbit_camera_position_update_test.sv]
`timescale 1ns / 1ps

module orbit_camera_position_update_test;

	localparam int KEY_LEFT    = 0;
	localparam int KEY_RIGHT   = 1;
	localparam int KEY_UP      = 2;
	localparam int KEY_DOWN    = 3;
	localparam int KEY_CLOSER  = 4;
	localparam int KEY_FARTHER = 5;

	localparam longint FULL_TURN  = 92160;
	localparam longint HALF_TURN  = 46080;
	localparam longint RIGHT_ANG  = 23040;
	localparam longint TILT_MAX   = 22784;
	localparam longint DIST_MIN   = 256;
	localparam longint DIST_MAX   = 23040;
	localparam longint EYE_MAX    = 23040;
	localparam longint INV_GAIN   = 652032874;
	localparam int     SETTLE     = 2 * ocp_pkg::CORDIC_N + 20;

	typedef struct {
		bit          is_speed;
		logic [15:0] value;
		logic [5:0]  keys;
	} stim_t;

	typedef struct {
		longint eye_x;
		longint eye_y;
		longint eye_z;
		longint yaw;
		longint pitch;
		longint radius;
	} camera_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [5:0] key flags, [21:6] elapsed_time, [23:22] zero
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [15:0] eye_x, [31:16] eye_y, [47:32] eye_z, [64:48] yaw_now,
	// [80:65] pitch_now, [95:81] radius_now
	logic [95:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	stim_t        pending_steps[$];
	camera_view_t view_expect[$];
	int           errors = 0;
	int           items_taken = 0;
	logic         steady;

	// Reference copy of the camera state and the speed register.
	longint speed_q88;
	longint yaw_q8;
	longint pitch_q8;
	longint radius_q8;

	longint arctan_step [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	assign steady = (items_taken >= 600) && (items_taken < 900);

	orbit_camera_position_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Angle in degrees * 65536; cos and sin come out in Q2.30.
	function automatic void rotate_vector(input longint ang, output longint c,
		output longint s);
		longint x, y, z, xs, ys;
		x = INV_GAIN;
		y = 0;
		z = ang;
		for (int i = 0; i < ocp_pkg::CORDIC_N; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_step[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_step[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint round30(input longint v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

	function automatic longint limit_eye(input longint v);
		if (v > EYE_MAX)
			return EYE_MAX;
		if (v < -EYE_MAX)
			return -EYE_MAX;
		return v;
	endfunction

	function automatic camera_view_t advance_camera(input logic [5:0] keys,
		input logic [15:0] dt);
		camera_view_t v;
		longint delta, ya, cp, sp, cy, sy, f;
		bit flip;
		delta = (longint'(dt) * speed_q88 + 32768) >>> 16;
		if (keys[KEY_LEFT]) begin
			yaw_q8 = yaw_q8 + delta;
			if (yaw_q8 >= FULL_TURN)
				yaw_q8 = yaw_q8 - FULL_TURN;
		end
		if (keys[KEY_RIGHT]) begin
			yaw_q8 = yaw_q8 + FULL_TURN - delta;
			if (yaw_q8 >= FULL_TURN)
				yaw_q8 = yaw_q8 - FULL_TURN;
		end
		if (keys[KEY_UP])
			pitch_q8 = pitch_q8 + delta;
		if (keys[KEY_DOWN])
			pitch_q8 = pitch_q8 - delta;
		if (keys[KEY_CLOSER])
			radius_q8 = radius_q8 - delta;
		if (keys[KEY_FARTHER])
			radius_q8 = radius_q8 + delta;
		if (pitch_q8 > TILT_MAX)
			pitch_q8 = TILT_MAX;
		else if (pitch_q8 < -TILT_MAX)
			pitch_q8 = -TILT_MAX;
		if (radius_q8 < DIST_MIN)
			radius_q8 = DIST_MIN;
		else if (radius_q8 > DIST_MAX)
			radius_q8 = DIST_MAX;

		rotate_vector(pitch_q8 * 256, cp, sp);
		// Bring yaw into -90..+90 degrees; a half-turn shift negates cos and sin.
		ya = yaw_q8;
		flip = 1'b0;
		if (ya > HALF_TURN)
			ya = ya - FULL_TURN;
		if (ya > RIGHT_ANG) begin
			ya = ya - HALF_TURN;
			flip = 1'b1;
		end else if (ya < -RIGHT_ANG) begin
			ya = ya + HALF_TURN;
			flip = 1'b1;
		end
		rotate_vector(ya * 256, cy, sy);
		if (flip) begin
			cy = -cy;
			sy = -sy;
		end

		f = round30(cp * cy);
		v.eye_x = limit_eye(round30(radius_q8 * f));
		v.eye_y = limit_eye(round30(radius_q8 * sp));
		f = round30(cp * sy);
		v.eye_z = limit_eye(round30(radius_q8 * f));
		v.yaw = yaw_q8;
		v.pitch = pitch_q8;
		v.radius = radius_q8;
		return v;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic add_step(input logic [5:0] keys, input logic [15:0] dt);
		stim_t s;
		s.is_speed = 1'b0;
		s.keys = keys;
		s.value = dt;
		pending_steps.push_back(s);
	endtask

	task automatic add_speed(input logic [15:0] speed);
		stim_t s;
		s.is_speed = 1'b1;
		s.keys = '0;
		s.value = speed;
		pending_steps.push_back(s);
	endtask

	task automatic add_random_steps(input int count);
		logic [15:0] dt;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 60)
				dt = 16'($urandom_range(0, 4095));
			else
				dt = 16'($urandom_range(0, 65535));
			add_step(6'($urandom), dt);
		end
	endtask

	// Driver: items and speed writes leave the queue in order; a speed write
	// waits until every result of the items before it has come back.
	always @(posedge clk or negedge arst_n) begin : driver
		logic next_valid, next_cfg;
		camera_view_t view;
		stim_t head;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			speed_q88 = 256;
			yaw_q8 = 3840;
			pitch_q8 = 1920;
			radius_q8 = 3840;
		end else begin
			next_valid = s_tvalid && !s_tready;
			next_cfg = cfg_valid && !cfg_ready;
			if (s_tvalid && s_tready) begin
				view = advance_camera(s_tdata[5:0], s_tdata[21:6]);
				view_expect.push_back(view);
				items_taken++;
			end
			if (cfg_valid && cfg_ready)
				speed_q88 = cfg_data;
			if (!next_valid && !next_cfg && pending_steps.size() != 0) begin
				head = pending_steps[0];
				if (head.is_speed) begin
					if (view_expect.size() == 0) begin
						next_cfg = 1'b1;
						cfg_data <= head.value;
						void'(pending_steps.pop_front());
					end
				end else if (steady || $urandom_range(0, 99) >= 15) begin
					next_valid = 1'b1;
					s_tdata <= {2'b00, head.value, head.keys};
					void'(pending_steps.pop_front());
				end
			end
			s_tvalid <= next_valid;
			cfg_valid <= next_cfg;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		camera_view_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (view_expect.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, got %h", $time, m_tdata);
				end else begin
					want = view_expect.pop_front();
					check_field("eye_x", want.eye_x, $signed(m_tdata[15:0]));
					check_field("eye_y", want.eye_y, $signed(m_tdata[31:16]));
					check_field("eye_z", want.eye_z, $signed(m_tdata[47:32]));
					check_field("yaw_now", want.yaw, m_tdata[64:48]);
					check_field("pitch_now", want.pitch, $signed(m_tdata[80:65]));
					check_field("radius_now", want.radius, m_tdata[95:81]);
				end
			end
			m_tready <= steady || ($urandom_range(0, 99) >= 15);
		end
	end

	initial begin
		// Reset state, then all pairs pressed at once so every change cancels.
		add_step(6'b000000, 16'd0);
		add_step(6'b111111, 16'd65535);
		add_speed(16'd65535);
		// Largest delta drives pitch and radius into both clamps.
		add_step(6'b1 << KEY_UP, 16'd65535);
		add_step(6'b1 << KEY_DOWN, 16'd65535);
		add_step(6'b1 << KEY_FARTHER, 16'd65535);
		add_step(6'b1 << KEY_CLOSER, 16'd65535);
		add_step(6'b1 << KEY_FARTHER, 16'd65535);
		// Level pitch and zero yaw at full radius push eye_x to its limit.
		add_step(6'b1 << KEY_UP, 16'd22784);
		add_step(6'b1 << KEY_RIGHT, 16'd3840);
		// Yaw wraps below zero and back, then across 360 degrees.
		add_step(6'b1 << KEY_RIGHT, 16'd1);
		add_step(6'b1 << KEY_LEFT, 16'd1);
		add_step(6'b1 << KEY_LEFT, 16'd65535);
		add_step(6'b1 << KEY_LEFT, 16'd65535);
		add_step(6'b1 << KEY_RIGHT, 16'd65535);
		add_step(6'b111111, 16'd40000);
		add_step(6'b1 << KEY_DOWN, 16'd43690);
		add_step(6'b1 << KEY_CLOSER, 16'd21845);
		add_speed(16'd0);
		add_step(6'b010101, 16'd65535);
		add_step(6'b101010, 16'd65535);

		add_speed(16'd256);
		add_random_steps(250);
		add_speed(16'd65535);
		add_random_steps(250);
		add_speed(16'($urandom_range(1, 65535)));
		add_random_steps(250);
		add_speed(16'd3000);
		add_random_steps(250);
		add_speed(16'($urandom_range(0, 65535)));
		add_random_steps(250);
		add_speed(16'd1);
		add_random_steps(250);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (pending_steps.size() != 0 || s_tvalid || cfg_valid || view_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && view_expect.size() == 0)
			$display("[orbit_camera_position_update] OK");
		else
			$display("[orbit_camera_position_update] ERROR");
		$finish;
	end

	initial begin
		#10ms;
		$display("[orbit_camera_position_update] ERROR");
		$finish;
	end

endmodule
